/* rtl/core/ofw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Oscillator frequency word package
// Widths, limits, octave thresholds and pipeline types shared by the
// interfaces and the conversion pipeline.
// ----------------------------------------------------------------------------
package ofw_pkg;

    // Width of the requested frequency; valid for 27 to 32.
    localparam int FREQ_BITS   = 27;
    localparam int MODE_W      = 2;
    localparam int OCT_W       = 4;
    localparam int DAC_W       = 10;
    localparam int WORD_W      = 16;

    // Range of a valid request, both bounds inclusive.
    localparam int unsigned FREQ_MIN  = 32'd1039;
    localparam int unsigned FREQ_MAX  = 32'd68030000;

    // DAC code = DAC_BASE - ceil(DAC_SCALE * 2^(SCALE_SHIFT + octave) / f).
    localparam int DAC_BASE    = 2048;
    localparam int DAC_SCALE   = 2078;
    localparam int DAC_MAX     = 1023;
    localparam int SCALE_SHIFT = 10;

    // The quotient always stays below 2^QUO_W for an in-range request.
    localparam int QUO_W       = 12;
    // Rounded-up numerator: DAC_SCALE << 25 plus f - 1 stays below 2^38.
    localparam int NUM_W       = 38;

    // Capture stage, numerator stage, then one stage per quotient bit.
    localparam int STAGES      = 2 + QUO_W;

    localparam int N_LIMITS    = 15;

    // Exclusive upper limits of octaves 0 to 14; anything at or above the last is octave 15.
    localparam logic [31:0] OCT_LIMIT [N_LIMITS] = '{
        32'd2076,    32'd4152,    32'd8304,    32'd16610,   32'd33220,
        32'd66430,   32'd132900,  32'd265700,  32'd531400,  32'd1063000,
        32'd2126000, 32'd4252000, 32'd8503000, 32'd17010000, 32'd34010000
    };

    typedef logic [FREQ_BITS-1:0] t_freq;
    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [OCT_W-1:0]     t_oct;
    typedef logic [DAC_W-1:0]     t_dac;
    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [NUM_W-1:0]     t_num;
    typedef logic [QUO_W-1:0]     t_quo;

    // Payload carried along the pipeline.
    typedef struct packed {
        t_freq freq;
        t_mode mode;
        logic  bad;
        t_oct  oct;
        t_num  num;
        t_freq rem;
        t_quo  quo;
    } t_stage;

    typedef struct packed {
        logic  status;
        t_word word;
        t_oct  oct;
        t_dac  dac;
    } t_result;

    // Octave: the first threshold that the frequency lies below.
    function automatic t_oct pick_octave(input t_freq f);
        t_oct oct;
        oct = OCT_W'(N_LIMITS);
        for (int k = N_LIMITS - 1; k >= 0; k--) begin
            if (32'(f) < OCT_LIMIT[k]) begin
                oct = OCT_W'(k);
            end
        end
        return oct;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/ofw_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Oscillator frequency request channel
// Valid/ready channel carrying a requested frequency and an output mode.
// ----------------------------------------------------------------------------
interface ofw_req_if;
    logic                 valid;
    logic                 ready;
    ofw_pkg::t_freq       frequency_hz;
    ofw_pkg::t_mode       output_mode;

    modport source (output valid, output frequency_hz, output output_mode, input ready);
    modport sink   (input valid, input frequency_hz, input output_mode, output ready);
endinterface
`default_nettype wire

/* rtl/core/ofw_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Oscillator control word channel
// Valid/ready channel carrying the status, control word, octave and DAC code.
// ----------------------------------------------------------------------------
interface ofw_rsp_if;
    logic                 valid;
    logic                 ready;
    logic                 status;
    ofw_pkg::t_word       control_word;
    ofw_pkg::t_oct        octave;
    ofw_pkg::t_dac        dac_code;

    modport source (output valid, output status, output control_word, output octave,
                    output dac_code, input ready);
    modport sink   (input valid, input status, input control_word, input octave,
                    input dac_code, output ready);
endinterface
`default_nettype wire

/* rtl/core/oscillator_frequency_word.sv */
// A result is offered from the output register after its request has passed
// the capture, numerator and twelve restoring-division stages, each of which
// settles one quotient bit. Throughput: one request per cycle unless stalled.
// Each stage keeps its item while the next is occupied and stalled, so
// bubbles are squeezed out and nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) empties every stage and the output register.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Oscillator frequency word
// Converts a requested frequency in hertz and an output mode into the
// oscillator's 16-bit control word: octave, saturated DAC code and mode.
// ----------------------------------------------------------------------------
module oscillator_frequency_word (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ofw_req_if.sink      i_req,
    ofw_rsp_if.source    o_rsp
);

    localparam int LAST = ofw_pkg::STAGES - 1;

    // One step of restoring division. The numerator is shifted left so that
    // the bit brought down always sits at the top of the quotient window, and
    // the new quotient bit enters at the bottom.
    function automatic ofw_pkg::t_stage div_step(input ofw_pkg::t_stage s);
        ofw_pkg::t_stage                  o;
        logic [ofw_pkg::FREQ_BITS:0]      trial;
        logic [ofw_pkg::FREQ_BITS:0]      diff;
        logic                             qbit;
        o     = s;
        trial = {s.rem, s.num[ofw_pkg::QUO_W-1]};
        diff  = trial - {1'b0, s.freq};
        qbit  = (trial >= {1'b0, s.freq});
        o.rem = qbit ? diff[ofw_pkg::FREQ_BITS-1:0] : trial[ofw_pkg::FREQ_BITS-1:0];
        o.num = {s.num[ofw_pkg::NUM_W-2:0], 1'b0};
        o.quo = {s.quo[ofw_pkg::QUO_W-2:0], qbit};
        return o;
    endfunction

    // Pipeline registers: stage 0 holds the captured request with its range
    // check and octave, stage 1 the rounded-up numerator, and stages 2 onwards
    // each settle one quotient bit, most significant first.
    logic [ofw_pkg::STAGES-1:0] r_v;
    ofw_pkg::t_stage            r_pl [ofw_pkg::STAGES];
    ofw_pkg::t_stage            n_pl [ofw_pkg::STAGES];
    logic [ofw_pkg::STAGES-1:0] w_load;
    logic                       w_move_last;

    logic                       r_out_v;
    ofw_pkg::t_result           r_out;
    ofw_pkg::t_result           n_out;

    // A stage takes a new item when it is empty or its own item moves on.
    always_comb begin
        w_move_last  = !r_out_v || o_rsp.ready;
        w_load[LAST] = !r_v[LAST] || w_move_last;
        for (int s = LAST - 1; s >= 0; s--) begin
            w_load[s] = !r_v[s] || w_load[s + 1];
        end
    end

    assign i_req.ready = w_load[0];

    // Stage payloads.
    always_comb begin
        logic [5:0] shamt;

        n_pl[0].freq = i_req.frequency_hz;
        n_pl[0].mode = i_req.output_mode;
        n_pl[0].bad  = (32'(i_req.frequency_hz) < ofw_pkg::FREQ_MIN) ||
                       (32'(i_req.frequency_hz) > ofw_pkg::FREQ_MAX);
        n_pl[0].oct  = ofw_pkg::pick_octave(i_req.frequency_hz);
        n_pl[0].num  = '0;
        n_pl[0].rem  = '0;
        n_pl[0].quo  = '0;

        // Adding f - 1 before dividing rounds the quotient up. The top part
        // of the numerator, above the quotient window, seeds the remainder.
        shamt        = 6'(ofw_pkg::SCALE_SHIFT) + 6'(r_pl[0].oct);
        n_pl[1]      = r_pl[0];
        n_pl[1].num  = (ofw_pkg::NUM_W'(ofw_pkg::DAC_SCALE) << shamt)
                     + ofw_pkg::NUM_W'(r_pl[0].freq) - ofw_pkg::NUM_W'(1);
        n_pl[1].rem  = ofw_pkg::FREQ_BITS'(n_pl[1].num >> ofw_pkg::QUO_W);
        n_pl[1].quo  = '0;

        for (int s = 2; s < ofw_pkg::STAGES; s++) begin
            n_pl[s] = div_step(r_pl[s - 1]);
        end
    end

    // Saturation of the DAC code and packing of the control word.
    always_comb begin
        logic [ofw_pkg::QUO_W-1:0] code;
        ofw_pkg::t_dac             dac;
        code = ofw_pkg::QUO_W'(ofw_pkg::DAC_BASE) - r_pl[LAST].quo;
        if (r_pl[LAST].quo > ofw_pkg::QUO_W'(ofw_pkg::DAC_BASE)) begin
            dac = '0;
        end else if (code > ofw_pkg::QUO_W'(ofw_pkg::DAC_MAX)) begin
            dac = ofw_pkg::DAC_W'(ofw_pkg::DAC_MAX);
        end else begin
            dac = code[ofw_pkg::DAC_W-1:0];
        end

        if (r_pl[LAST].bad) begin
            n_out.status = 1'b1;
            n_out.word   = '0;
            n_out.oct    = '0;
            n_out.dac    = '0;
        end else begin
            n_out.status = 1'b0;
            n_out.word   = {r_pl[LAST].oct, dac, r_pl[LAST].mode};
            n_out.oct    = r_pl[LAST].oct;
            n_out.dac    = dac;
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (w_load[0]) begin
                r_v[0] <= i_req.valid;
            end
            for (int s = 1; s < ofw_pkg::STAGES; s++) begin
                if (w_load[s]) begin
                    r_v[s] <= r_v[s - 1];
                end
            end
            if (w_move_last) begin
                r_out_v <= r_v[LAST];
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < ofw_pkg::STAGES; s++) begin
            if (w_load[s]) begin
                r_pl[s] <= n_pl[s];
            end
        end
        if (w_move_last) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid        = r_out_v;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.control_word = r_out.word;
    assign o_rsp.octave       = r_out.oct;
    assign o_rsp.dac_code     = r_out.dac;

`ifndef SYNTHESIS
    // A rejected frequency leaves every result field at zero.
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status) |->
        (o_rsp.control_word == '0 && o_rsp.octave == '0 && o_rsp.dac_code == '0))
        else $error("rejected request produced a non-zero result");

    // The packed word agrees with the separate octave and DAC fields.
    a_word_packing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.status) |->
        (o_rsp.control_word[15:12] == o_rsp.octave &&
         o_rsp.control_word[11:2] == o_rsp.dac_code))
        else $error("control word does not match octave and DAC code");

    // Every request transaction lands in the capture stage.
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_v[0])
        else $error("accepted request missing from the capture stage");

    // A finished item waiting behind a stalled output is kept.
    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[LAST] && !w_move_last) |=> (r_v[LAST] && $stable(r_pl[LAST])))
        else $error("last pipeline stage lost its item during a stall");
`endif

endmodule
`default_nettype wire
